### src/dmxtx_pkg.sv
// dmx512 transmitter package: shared types, codes and reset constants
`timescale 1ns / 1ps
`default_nettype none

package dmxtx_pkg;

    // store depth default and fixed field widths
    localparam int MAX_SLOTS_DEF  = 512;
    localparam int SLOT_IDX_W     = 9;
    localparam int SLOT_CNT_W     = 10;
    localparam int TICK_W         = 16;
    localparam int BIT_CNT_W      = 4;
    localparam int SHIFT_W        = 11;

    // bits in one character: start, 8 data, 2 stop
    localparam logic [BIT_CNT_W-1:0] BITS_PER_CHAR = 4'd11;

    // register reset values
    localparam logic [TICK_W-1:0] TICKS_PER_BIT_RST = 16'd4;
    localparam logic [TICK_W-1:0] BREAK_TICKS_RST   = 16'd176;
    localparam logic [TICK_W-1:0] MARK_TICKS_RST    = 16'd12;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_STOPPED = 2'd0,
        PH_BREAK   = 2'd1,
        PH_MARK    = 2'd2,
        PH_DATA    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CFG_SLOT_COUNT    = 2'd0,
        CFG_TICKS_PER_BIT = 2'd1,
        CFG_BREAK_TICKS   = 2'd2,
        CFG_MARK_TICKS    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        cmd_t                  command;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [7:0]            slot_value;
    } item_t;

    typedef struct packed {
        logic                  line_level;
        phase_t                frame_phase;
        logic [SLOT_CNT_W-1:0] slot_number;
        logic                  frame_done;
    } result_t;

    typedef struct packed {
        logic              en;
        cfg_idx_t          index;
        logic [TICK_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] addr;
        logic [7:0]            data;
    } store_wr_t;

    // a zero timing register behaves as one
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        logic [TICK_W-1:0] r;
        r = (v == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : v;
        return r;
    endfunction

endpackage

`default_nettype wire

### src/dmxtx_if.sv
// dmx512 transmitter channel interfaces: request, result and register write
`timescale 1ns / 1ps
`default_nettype none

interface dmxtx_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [8:0] slot_index;
    logic [7:0] slot_value;

    modport source (output valid, command, slot_index, slot_value, input ready);
    modport sink   (input valid, command, slot_index, slot_value, output ready);
endinterface

interface dmxtx_result_if;
    logic       valid;
    logic       ready;
    logic       line_level;
    logic [1:0] frame_phase;
    logic [9:0] slot_number;
    logic       frame_done;

    modport source (output valid, line_level, frame_phase, slot_number, frame_done,
                    input ready);
    modport sink   (input valid, line_level, frame_phase, slot_number, frame_done,
                    output ready);
endinterface

interface dmxtx_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/dmxtx_store.sv
// slot byte memory with clearing sweep after reset and write bypass
`timescale 1ns / 1ps
`default_nettype none

module dmxtx_store #(
    parameter int MAX_SLOTS = dmxtx_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire dmxtx_pkg::store_wr_t                 wr,
    input  wire logic [dmxtx_pkg::SLOT_CNT_W-1:0]     rd_slot,
    output logic [7:0]                                rd_byte,
    output logic                                      busy
);

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS - 1);

    logic [7:0]    mem [MAX_SLOTS];
    logic [7:0]    rd_q;

    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic          lw_valid_reg;
    logic [AW-1:0] lw_addr_reg;
    logic [7:0]    lw_data_reg;
    logic [AW-1:0] rd_addr_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;

    function automatic logic [dmxtx_pkg::SLOT_CNT_W-1:0] SLOT_CNT_LIMIT();
        return dmxtx_pkg::SLOT_CNT_W'(MAX_SLOTS);
    endfunction

    // clearing sweep owns the write port while busy
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
                clr_busy_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + 1'b1;
        end
        we    = clr_busy_reg | wr.en;
        waddr = clr_busy_reg ? clr_addr_reg : wr.addr[AW-1:0];
        wdata = clr_busy_reg ? 8'h00 : wr.data;
        raddr = (rd_slot < SLOT_CNT_LIMIT()) ? rd_slot[AW-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_q        <= mem[raddr];
        lw_addr_reg <= waddr;
        lw_data_reg <= wdata;
        rd_addr_reg <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            lw_valid_reg <= we;
        end
    end

    // read-first array: a write in the read cycle is forwarded
    assign rd_byte = (lw_valid_reg && (lw_addr_reg == rd_addr_reg)) ? lw_data_reg : rd_q;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

### src/dmxtx_seq.sv
// frame sequencer: break, mark, character shifter and timing registers
`timescale 1ns / 1ps
`default_nettype none

module dmxtx_seq #(
    parameter int MAX_SLOTS = dmxtx_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             accept,
    input  wire dmxtx_pkg::item_t                 item,
    input  wire dmxtx_pkg::cfg_wr_t               cfg_wr,
    input  wire logic [7:0]                       rd_byte,
    output dmxtx_pkg::store_wr_t                  store_wr,
    output logic [dmxtx_pkg::SLOT_CNT_W-1:0]      rd_slot,
    output dmxtx_pkg::result_t                    result
);

    localparam int CW = dmxtx_pkg::SLOT_CNT_W;
    localparam int TW = dmxtx_pkg::TICK_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SLOTS);
    localparam logic [CW-1:0] SLOT_COUNT_RST = (MAX_SLOTS < 512) ? MAX_CNT : 10'd512;
    localparam logic [dmxtx_pkg::SHIFT_W-1:0] SHIFT_IDLE = '1;

    dmxtx_pkg::phase_t                   phase_reg, phase_next;
    logic [TW-1:0]                       tick_reg, tick_next;
    logic [dmxtx_pkg::BIT_CNT_W-1:0]     bit_reg, bit_next;
    logic [dmxtx_pkg::SHIFT_W-1:0]       shift_reg, shift_next;
    logic [CW-1:0]                       slot_reg, slot_next;
    logic                                stop_reg, stop_next;

    logic [CW-1:0] slot_count_reg;
    logic [TW-1:0] tpb_reg, break_reg, mark_reg;

    logic [TW-1:0]                   tick_inc;
    logic [dmxtx_pkg::BIT_CNT_W-1:0] bit_inc;
    logic                            done;

    function automatic logic SLOT_IDX_OK(input logic [dmxtx_pkg::SLOT_IDX_W-1:0] idx);
        return ({1'b0, idx} < MAX_CNT);
    endfunction

    // register writes, slot count saturates at the store depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RST;
            tpb_reg        <= dmxtx_pkg::TICKS_PER_BIT_RST;
            break_reg      <= dmxtx_pkg::BREAK_TICKS_RST;
            mark_reg       <= dmxtx_pkg::MARK_TICKS_RST;
        end
        else if (cfg_wr.en)
        begin
            unique case (cfg_wr.index)
                dmxtx_pkg::CFG_SLOT_COUNT:
                    slot_count_reg <= (cfg_wr.data[CW-1:0] > MAX_CNT) ? MAX_CNT
                                                                      : cfg_wr.data[CW-1:0];
                dmxtx_pkg::CFG_TICKS_PER_BIT: tpb_reg   <= cfg_wr.data;
                dmxtx_pkg::CFG_BREAK_TICKS:   break_reg <= cfg_wr.data;
                dmxtx_pkg::CFG_MARK_TICKS:    mark_reg  <= cfg_wr.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        slot_next  = slot_reg;
        stop_next  = stop_reg;
        done       = 1'b0;
        tick_inc   = tick_reg + 1'b1;
        bit_inc    = bit_reg + 1'b1;
        store_wr   = '0;

        if (accept)
        begin
            unique case (item.command)
                dmxtx_pkg::CMD_TICK:
                begin
                    unique case (phase_reg)
                        dmxtx_pkg::PH_BREAK:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= dmxtx_pkg::at_least_one(break_reg))
                            begin
                                phase_next = dmxtx_pkg::PH_MARK;
                                tick_next  = '0;
                            end
                        end
                        dmxtx_pkg::PH_MARK:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= dmxtx_pkg::at_least_one(mark_reg))
                            begin
                                // start code goes out first
                                phase_next = dmxtx_pkg::PH_DATA;
                                slot_next  = '0;
                                shift_next = {2'b11, 8'h00, 1'b0};
                                bit_next   = '0;
                                tick_next  = '0;
                            end
                        end
                        dmxtx_pkg::PH_DATA:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= dmxtx_pkg::at_least_one(tpb_reg))
                            begin
                                tick_next  = '0;
                                shift_next = {1'b1, shift_reg[dmxtx_pkg::SHIFT_W-1:1]};
                                bit_next   = bit_inc;
                                if (bit_inc >= dmxtx_pkg::BITS_PER_CHAR)
                                begin
                                    done = (slot_reg >= slot_count_reg);
                                    if (stop_reg || done)
                                    begin
                                        phase_next = stop_reg ? dmxtx_pkg::PH_STOPPED
                                                              : dmxtx_pkg::PH_BREAK;
                                        bit_next   = '0;
                                        shift_next = SHIFT_IDLE;
                                        slot_next  = '0;
                                        stop_next  = 1'b0;
                                    end
                                    else
                                    begin
                                        slot_next  = slot_reg + 1'b1;
                                        shift_next = {2'b11, rd_byte, 1'b0};
                                        bit_next   = '0;
                                    end
                                end
                            end
                        end
                        dmxtx_pkg::PH_STOPPED: ;
                        default: ;
                    endcase
                end
                dmxtx_pkg::CMD_WRITE:
                begin
                    if (SLOT_IDX_OK(item.slot_index))
                    begin
                        store_wr.en   = 1'b1;
                        store_wr.addr = item.slot_index;
                        store_wr.data = item.slot_value;
                    end
                end
                dmxtx_pkg::CMD_START:
                begin
                    phase_next = dmxtx_pkg::PH_BREAK;
                    tick_next  = '0;
                    bit_next   = '0;
                    shift_next = SHIFT_IDLE;
                    slot_next  = '0;
                    stop_next  = 1'b0;
                end
                dmxtx_pkg::CMD_STOP:
                begin
                    priority if (phase_reg == dmxtx_pkg::PH_BREAK ||
                                 phase_reg == dmxtx_pkg::PH_MARK)
                    begin
                        phase_next = dmxtx_pkg::PH_STOPPED;
                        tick_next  = '0;
                        bit_next   = '0;
                        shift_next = SHIFT_IDLE;
                        slot_next  = '0;
                        stop_next  = 1'b0;
                    end
                    else if (phase_reg == dmxtx_pkg::PH_DATA)
                        stop_next = 1'b1;
                    else
                        stop_next = stop_reg;
                end
                default: ;
            endcase
        end

        result.frame_phase = phase_next;
        result.frame_done  = done;
        result.slot_number = (phase_next == dmxtx_pkg::PH_DATA) ? slot_next : '0;
        unique case (phase_next)
            dmxtx_pkg::PH_BREAK: result.line_level = 1'b0;
            dmxtx_pkg::PH_DATA:  result.line_level = shift_next[0];
            default:             result.line_level = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dmxtx_pkg::PH_STOPPED;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= SHIFT_IDLE;
            slot_reg  <= '0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            slot_reg  <= slot_next;
            stop_reg  <= stop_next;
        end
    end

    // next character's byte is fetched ahead while the slot counter holds
    assign rd_slot = slot_reg;

endmodule

`default_nettype wire

### src/dmxtx_outq.sv
// two-entry result queue between sequencer and result channel
`timescale 1ns / 1ps
`default_nettype none

module dmxtx_outq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire dmxtx_pkg::result_t  push_data,
    input  wire logic                pop_ready,
    output logic                     head_valid,
    output dmxtx_pkg::result_t       head_data,
    output logic                     full
);

    dmxtx_pkg::result_t buf0_reg, buf0_next;
    dmxtx_pkg::result_t buf1_reg, buf1_next;
    logic [1:0]         count_reg, count_next;
    logic               pop;

    always_comb
    begin
        pop        = pop_ready && (count_reg != 2'd0);
        buf0_next  = buf0_reg;
        buf1_next  = buf1_reg;
        count_next = count_reg;
        priority if (push && pop)
        begin
            if (count_reg == 2'd2)
            begin
                buf0_next = buf1_reg;
                buf1_next = push_data;
            end
            else
                buf0_next = push_data;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                buf0_next = push_data;
            else
                buf1_next = push_data;
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            buf0_next  = buf1_reg;
            count_next = count_reg - 1'b1;
        end
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk)
    begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    assign head_valid = (count_reg != 2'd0);
    assign head_data  = buf0_reg;
    assign full       = (count_reg == 2'd2);

endmodule

`default_nettype wire

### src/dmx512_frame_transmitter_core.sv
// dmx512 frame transmitter top level: sequencer, slot store and result queue
// a request's result is held in the result queue from the cycle after its acceptance
// throughput: one request per cycle while the result queue has room, ticks and slot writes alike; two results may wait
// the slot byte for the next character is read ahead from the registered store port
// reset: registers take their defaults, line idle high, phase stopped
// after reset the store is swept to zero through every slot; no request is taken then
`timescale 1ns / 1ps
`default_nettype none

module dmx512_frame_transmitter_core #(
    parameter int MAX_SLOTS = dmxtx_pkg::MAX_SLOTS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    dmxtx_item_if.sink      items,
    dmxtx_result_if.source  results,
    dmxtx_cfg_if.sink       cfg
);

    // request side
    dmxtx_pkg::item_t     item;
    logic                 item_accept;
    logic                 clear_busy;
    logic                 q_full;

    // sequencer to store
    dmxtx_pkg::store_wr_t                  store_wr;
    logic [dmxtx_pkg::SLOT_CNT_W-1:0]      rd_slot;
    logic [7:0]                            rd_byte;

    // register write port, always ready
    dmxtx_pkg::cfg_wr_t   cfg_wr;

    // result path
    dmxtx_pkg::result_t   res;
    dmxtx_pkg::result_t   head;
    logic                 head_valid;

    assign item.command    = dmxtx_pkg::cmd_t'(items.command);
    assign item.slot_index = items.slot_index;
    assign item.slot_value = items.slot_value;

    // take a request whenever the sweep is over and the queue has room
    assign items.ready = !clear_busy && !q_full;
    assign item_accept = items.valid && items.ready;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.en    = cfg.valid;
    assign cfg_wr.index = dmxtx_pkg::cfg_idx_t'(cfg.index);
    assign cfg_wr.data  = cfg.data;

    dmxtx_seq #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (item_accept),
        .item     (item),
        .cfg_wr   (cfg_wr),
        .rd_byte  (rd_byte),
        .store_wr (store_wr),
        .rd_slot  (rd_slot),
        .result   (res)
    );

    // slot bytes live here, forwarded when written just before the fetch
    dmxtx_store #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (store_wr),
        .rd_slot (rd_slot),
        .rd_byte (rd_byte),
        .busy    (clear_busy)
    );

    // output register plus skid entry
    dmxtx_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (item_accept),
        .push_data  (res),
        .pop_ready  (results.ready),
        .head_valid (head_valid),
        .head_data  (head),
        .full       (q_full)
    );

    assign results.valid       = head_valid;
    assign results.line_level  = head.line_level;
    assign results.frame_phase = head.frame_phase;
    assign results.slot_number = head.slot_number;
    assign results.frame_done  = head.frame_done;

    // no request may slip in while the store is being cleared
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |-> !clear_busy)
        else $error("request accepted during store clearing");

    // a finished frame restarts or stops
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && res.frame_done) |->
            (res.frame_phase == dmxtx_pkg::PH_BREAK ||
             res.frame_phase == dmxtx_pkg::PH_STOPPED))
        else $error("frame_done outside frame end");

    // slot number only counts during characters
    a_slot_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && (res.slot_number != '0)) |->
            (res.frame_phase == dmxtx_pkg::PH_DATA))
        else $error("slot number outside character phase");

    // a waiting result is not lost when a new request enters
    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.ready && item_accept) |=> results.valid)
        else $error("result dropped from queue");

endmodule

`default_nettype wire

### bench/tb_dmx512_frame_transmitter_core.sv
// self-checking testbench for the dmx512 frame transmitter core
`timescale 1ns / 1ps

module tb_dmx512_frame_transmitter_core;

    // store depth used by the instance and by the line model
    localparam int SLOT_DEPTH      = dmxtx_pkg::MAX_SLOTS_DEF;
    localparam int TW              = dmxtx_pkg::TICK_W;
    localparam int CW              = dmxtx_pkg::SLOT_CNT_W;
    localparam int IW              = dmxtx_pkg::SLOT_IDX_W;
    // receiver hold-off long enough to fill the result queue and stall requests
    localparam int HOLD_CYCLES     = 300;
    // cycles with no handshake at all before the run is declared hung;
    // covers the store sweep after reset, the hold-off and the longest gaps
    localparam int WATCHDOG_LIMIT  = 2000;
    // settle time after the last result
    localparam int TAIL_CYCLES     = 8;
    // keep the log short when something goes badly wrong
    localparam int MAX_ERROR_LINES = 40;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dmxtx_item_if   item_ch ();
    dmxtx_result_if res_ch ();
    dmxtx_cfg_if    cfg_ch ();

    dmx512_frame_transmitter_core #(
        .MAX_SLOTS (SLOT_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // line model: mirror of the sequencer state and the register file
    // ------------------------------------------------------------------
    dmxtx_pkg::phase_t               ln_phase;
    logic [TW-1:0]                   ln_ticks;
    logic [dmxtx_pkg::BIT_CNT_W-1:0] ln_bits;
    logic [dmxtx_pkg::SHIFT_W-1:0]   ln_shift;
    logic [CW-1:0]                   ln_slot;
    logic                            ln_stop_pend;
    logic [7:0]                      slot_mem [SLOT_DEPTH];

    logic [CW-1:0] cfg_slots;
    logic [TW-1:0] cfg_bit_ticks;
    logic [TW-1:0] cfg_break_ticks;
    logic [TW-1:0] cfg_mark_ticks;

    // line samples still owed by the block, oldest first
    dmxtx_pkg::result_t line_expect_q [$];
    int                 error_count = 0;

    // knobs shared between the test tasks and the two handshake sides
    bit sender_idle_on = 1'b1;
    bit sink_idle_on   = 1'b1;
    int hold_requests  = 0;

    // a timing register of zero counts as one tick
    function automatic logic [TW-1:0] nonzero_len(input logic [TW-1:0] v);
        return (v == '0) ? TW'(1) : v;
    endfunction

    function automatic void go_idle();
        ln_phase     = dmxtx_pkg::PH_STOPPED;
        ln_ticks     = '0;
        ln_bits      = '0;
        ln_shift     = '1;
        ln_slot      = '0;
        ln_stop_pend = 1'b0;
    endfunction

    function automatic void begin_break();
        go_idle();
        ln_phase = dmxtx_pkg::PH_BREAK;
    endfunction

    // stop bits high, data lsb first, start bit low in bit 0
    function automatic void load_char(input logic [7:0] b);
        ln_shift = {2'b11, b, 1'b0};
        ln_bits  = '0;
        ln_ticks = '0;
    endfunction

    function automatic void reset_line_model();
        int i;
        cfg_slots       = CW'(SLOT_DEPTH);
        cfg_bit_ticks   = dmxtx_pkg::TICKS_PER_BIT_RST;
        cfg_break_ticks = dmxtx_pkg::BREAK_TICKS_RST;
        cfg_mark_ticks  = dmxtx_pkg::MARK_TICKS_RST;
        go_idle();
        for (i = 0; i < SLOT_DEPTH; i++)
            slot_mem[i] = 8'h00;
    endfunction

    function automatic void apply_register(input dmxtx_pkg::cfg_idx_t idx,
                                           input logic [TW-1:0] v);
        logic [CW-1:0] n;
        n = v[CW-1:0];
        case (idx)
            dmxtx_pkg::CFG_SLOT_COUNT:
                cfg_slots = (n > CW'(SLOT_DEPTH)) ? CW'(SLOT_DEPTH) : n;
            dmxtx_pkg::CFG_TICKS_PER_BIT: cfg_bit_ticks   = v;
            dmxtx_pkg::CFG_BREAK_TICKS:   cfg_break_ticks = v;
            dmxtx_pkg::CFG_MARK_TICKS:    cfg_mark_ticks  = v;
            default: ;
        endcase
    endfunction

    // one tick of line time; returns high when the last slot's stop bit ends
    function automatic logic advance_tick();
        logic          done;
        logic          last;
        logic [IW-1:0] rd;
        done = 1'b0;
        case (ln_phase)
            dmxtx_pkg::PH_BREAK:
            begin
                ln_ticks = ln_ticks + 1'b1;
                if (ln_ticks >= nonzero_len(cfg_break_ticks))
                begin
                    ln_phase = dmxtx_pkg::PH_MARK;
                    ln_ticks = '0;
                end
            end
            dmxtx_pkg::PH_MARK:
            begin
                ln_ticks = ln_ticks + 1'b1;
                if (ln_ticks >= nonzero_len(cfg_mark_ticks))
                begin
                    // start code goes out first
                    ln_phase = dmxtx_pkg::PH_DATA;
                    ln_slot  = '0;
                    load_char(8'h00);
                end
            end
            dmxtx_pkg::PH_DATA:
            begin
                ln_ticks = ln_ticks + 1'b1;
                if (ln_ticks >= nonzero_len(cfg_bit_ticks))
                begin
                    ln_ticks = '0;
                    ln_shift = {1'b1, ln_shift[dmxtx_pkg::SHIFT_W-1:1]};
                    ln_bits  = ln_bits + 1'b1;
                    if (ln_bits >= dmxtx_pkg::BITS_PER_CHAR)
                    begin
                        // a shrunk slot count ends the frame after this character
                        last = (ln_slot >= cfg_slots);
                        done = last;
                        if (ln_stop_pend)
                            go_idle();
                        else if (last)
                            begin_break();
                        else
                        begin
                            ln_slot = ln_slot + 1'b1;
                            rd      = IW'(ln_slot - 1'b1);
                            load_char(slot_mem[rd]);
                        end
                    end
                end
            end
            default: ;
        endcase
        return done;
    endfunction

    // applies one request to the model and returns the line sample it yields
    function automatic dmxtx_pkg::result_t line_after_request(input dmxtx_pkg::item_t req);
        dmxtx_pkg::result_t s;
        logic               done;
        done = 1'b0;
        case (req.command)
            dmxtx_pkg::CMD_TICK:  done = advance_tick();
            dmxtx_pkg::CMD_WRITE:
            begin
                if (int'(req.slot_index) < SLOT_DEPTH)
                    slot_mem[req.slot_index] = req.slot_value;
            end
            dmxtx_pkg::CMD_START: begin_break();
            dmxtx_pkg::CMD_STOP:
            begin
                // break or mark drop to idle now, a character runs to its end
                if (ln_phase == dmxtx_pkg::PH_BREAK || ln_phase == dmxtx_pkg::PH_MARK)
                    go_idle();
                else if (ln_phase == dmxtx_pkg::PH_DATA)
                    ln_stop_pend = 1'b1;
            end
            default: ;
        endcase
        case (ln_phase)
            dmxtx_pkg::PH_BREAK: s.line_level = 1'b0;
            dmxtx_pkg::PH_DATA:  s.line_level = ln_shift[0];
            default:             s.line_level = 1'b1;
        endcase
        s.frame_phase = ln_phase;
        s.slot_number = (ln_phase == dmxtx_pkg::PH_DATA) ? ln_slot : '0;
        s.frame_done  = done;
        return s;
    endfunction

    task automatic flag_error(input string msg);
        if (error_count < MAX_ERROR_LINES)
            $display("%0t ns  mismatch: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // checker: compares each accepted result, then records the register
    // write or request taken at the same edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : line_checker
        dmxtx_pkg::result_t got;
        dmxtx_pkg::result_t want;
        dmxtx_pkg::item_t   req;
        if (rst_n)
        begin
            // a result leaving now always belongs to an earlier request
            if (res_ch.valid && res_ch.ready)
            begin
                got.line_level  = res_ch.line_level;
                got.frame_phase = dmxtx_pkg::phase_t'(res_ch.frame_phase);
                got.slot_number = res_ch.slot_number;
                got.frame_done  = res_ch.frame_done;
                if (line_expect_q.size() == 0)
                    flag_error("result with no request outstanding");
                else
                begin
                    want = line_expect_q.pop_front();
                    if (got.line_level !== want.line_level)
                        flag_error($sformatf("line_level got %0b want %0b",
                                             got.line_level, want.line_level));
                    if (got.frame_phase !== want.frame_phase)
                        flag_error($sformatf("frame_phase got %0d want %0d",
                                             got.frame_phase, want.frame_phase));
                    if (got.slot_number !== want.slot_number)
                        flag_error($sformatf("slot_number got %0d want %0d",
                                             got.slot_number, want.slot_number));
                    if (got.frame_done !== want.frame_done)
                        flag_error($sformatf("frame_done got %0b want %0b",
                                             got.frame_done, want.frame_done));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                apply_register(dmxtx_pkg::cfg_idx_t'(cfg_ch.index), cfg_ch.data);
            if (item_ch.valid && item_ch.ready)
            begin
                req.command    = dmxtx_pkg::cmd_t'(item_ch.command);
                req.slot_index = item_ch.slot_index;
                req.slot_value = item_ch.slot_value;
                line_expect_q.push_back(line_after_request(req));
            end
        end
    end

    // watchdog: ends the run after a long stretch with no handshake
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns  timeout: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_dmx512_frame_transmitter_core failed");
        $finish;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: exactly one assignment to ready per edge
    initial
    begin : result_sink
        int gap_left;
        int hold_left;
        int holds_taken;
        gap_left     = 0;
        hold_left    = 0;
        holds_taken  = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (holds_taken != hold_requests)
            begin
                // long hold-off, counted here while the sender keeps offering
                holds_taken++;
                hold_left    = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (sink_idle_on && $urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // request side helpers
    // ------------------------------------------------------------------

    // valid stays high between back-to-back requests, it only drops for a gap
    task automatic send_request(input dmxtx_pkg::cmd_t c, input logic [IW-1:0] idx,
                                input logic [7:0] v);
        int gap;
        gap = sender_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.command    <= c;
        item_ch.slot_index <= idx;
        item_ch.slot_value <= v;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // ticks carry random index and value bits that the block must ignore
    task automatic send_ticks(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_request(dmxtx_pkg::CMD_TICK, IW'($urandom), 8'($urandom));
    endtask

    // sender pause until every line sample has come back
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (line_expect_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input dmxtx_pkg::cfg_idx_t r, input logic [TW-1:0] v);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [TW-1:0] bit_t, input logic [TW-1:0] brk,
                              input logic [TW-1:0] mab);
        write_register(dmxtx_pkg::CFG_TICKS_PER_BIT, bit_t);
        write_register(dmxtx_pkg::CFG_BREAK_TICKS, brk);
        write_register(dmxtx_pkg::CFG_MARK_TICKS, mab);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // tick and stop while stopped change nothing; fields at their extremes
    task automatic test_stopped_commands();
        send_request(dmxtx_pkg::CMD_TICK, 9'h000, 8'h00);
        send_request(dmxtx_pkg::CMD_STOP, 9'h1FF, 8'hFF);
        send_request(dmxtx_pkg::CMD_WRITE, 9'h1FF, 8'h5A);
        send_request(dmxtx_pkg::CMD_WRITE, 9'h000, 8'hFF);
    endtask

    // zero in every timing register acts as one; zero slots sends only the start code
    task automatic test_empty_frame_min_timing();
        write_register(dmxtx_pkg::CFG_SLOT_COUNT, 16'd0);
        set_timing(16'd0, 16'd0, 16'd0);
        send_request(dmxtx_pkg::CMD_START, 9'h0AA, 8'h55);
        // break, mark, start code, then the next break and its mark
        send_ticks(1 + 1 + 11 + 1);
        // stop in mark goes idle at once
        send_request(dmxtx_pkg::CMD_STOP, 9'h000, 8'h00);
    endtask

    // stop in break, restart over a pending stop, stop that lets a character finish
    task automatic test_stop_and_restart();
        write_register(dmxtx_pkg::CFG_SLOT_COUNT, 16'd1);
        send_request(dmxtx_pkg::CMD_START, 9'h000, 8'h00);
        send_request(dmxtx_pkg::CMD_STOP, 9'h000, 8'h00);
        send_request(dmxtx_pkg::CMD_START, 9'h000, 8'h00);
        send_ticks(3);
        send_request(dmxtx_pkg::CMD_STOP, 9'h000, 8'h00);
        send_request(dmxtx_pkg::CMD_START, 9'h000, 8'h00);
        send_ticks(5);
        // write while the start code is on the line, then stop after it
        send_request(dmxtx_pkg::CMD_WRITE, 9'h000, 8'hC3);
        send_request(dmxtx_pkg::CMD_STOP, 9'h000, 8'h00);
        send_ticks(12);
    endtask

    // shrinking a register below a running counter ends that phase on the next tick
    task automatic test_register_change_mid_phase();
        write_register(dmxtx_pkg::CFG_SLOT_COUNT, 16'd3);
        set_timing(16'd4, 16'd6, 16'd5);
        send_request(dmxtx_pkg::CMD_START, 9'h000, 8'h00);
        send_ticks(4);
        write_register(dmxtx_pkg::CFG_BREAK_TICKS, 16'd2);
        send_ticks(4);
        write_register(dmxtx_pkg::CFG_MARK_TICKS, 16'd1);
        send_ticks(3);
        write_register(dmxtx_pkg::CFG_TICKS_PER_BIT, 16'd1);
        send_ticks(30);
        write_register(dmxtx_pkg::CFG_SLOT_COUNT, 16'd1);
        send_ticks(14);
    endtask

    // largest register values; a slot count write above the store saturates
    task automatic test_long_registers();
        write_register(dmxtx_pkg::CFG_SLOT_COUNT, 16'hFFFF);
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(dmxtx_pkg::CMD_START, 9'h000, 8'h00);
        send_ticks(6);
        write_register(dmxtx_pkg::CFG_BREAK_TICKS, 16'd1);
        write_register(dmxtx_pkg::CFG_MARK_TICKS, 16'd1);
        send_ticks(8);
        send_request(dmxtx_pkg::CMD_STOP, 9'h000, 8'h00);
        send_ticks(2);
    endtask

    // mostly ticks through short frames, with writes and stray starts and stops
    task automatic test_random_frames(input int rounds, input int per_round);
        int r;
        int k;
        int pick;
        for (r = 0; r < rounds; r++)
        begin
            sender_idle_on = (r % 3 != 1);
            sink_idle_on   = (r % 4 != 2);
            if (r % 5 == 4)
                write_register(dmxtx_pkg::CFG_SLOT_COUNT,
                               {6'($urandom), 10'($urandom_range(513, 1023))});
            else
                write_register(dmxtx_pkg::CFG_SLOT_COUNT, 16'($urandom_range(0, 3)));
            set_timing(16'($urandom_range(0, 2)), 16'($urandom_range(0, 5)),
                       16'($urandom_range(0, 3)));
            send_request(dmxtx_pkg::CMD_START, 9'($urandom), 8'($urandom));
            for (k = 0; k < per_round; k++)
            begin
                pick = $urandom_range(0, 199);
                if (pick < 160)
                    send_ticks(1);
                else if (pick < 188)
                    send_request(dmxtx_pkg::CMD_WRITE,
                                 ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                             : 9'($urandom_range(0, 4)),
                                 8'($urandom));
                else if (pick < 194)
                    send_request(dmxtx_pkg::CMD_START, 9'($urandom), 8'($urandom));
                else
                    send_request(dmxtx_pkg::CMD_STOP, 9'($urandom), 8'($urandom));
            end
        end
        sender_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
    endtask

    // receiver holds off while requests keep coming, so the block must stall them
    task automatic test_result_backpressure();
        write_register(dmxtx_pkg::CFG_SLOT_COUNT, 16'd2);
        set_timing(16'd1, 16'd2, 16'd1);
        hold_requests++;
        sender_idle_on = 1'b0;
        send_request(dmxtx_pkg::CMD_START, 9'h000, 8'h00);
        send_ticks(40);
        sender_idle_on = 1'b1;
    endtask

    // sender goes quiet until everything is back, then resumes mid-frame
    task automatic test_sender_pause();
        send_ticks(20);
        wait_drained();
        send_ticks(20);
    endtask

    // slot count write above the store saturates; run through the first slots
    task automatic test_saturated_frame();
        write_register(dmxtx_pkg::CFG_SLOT_COUNT, 16'd700);
        set_timing(16'd1, 16'd1, 16'd1);
        sender_idle_on = 1'b0;
        send_request(dmxtx_pkg::CMD_START, 9'h000, 8'h00);
        send_ticks(1 + 1 + 12 * 11 + 3);
        sender_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        item_ch.valid      = 1'b0;
        item_ch.command    = dmxtx_pkg::CMD_TICK;
        item_ch.slot_index = '0;
        item_ch.slot_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = dmxtx_pkg::CFG_SLOT_COUNT;
        cfg_ch.data        = '0;
        reset_line_model();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_stopped_commands();
        test_empty_frame_min_timing();
        test_stop_and_restart();
        test_register_change_mid_phase();
        test_long_registers();
        test_random_frames(7, 120);
        test_result_backpressure();
        test_sender_pause();
        test_saturated_frame();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (line_expect_q.size() != 0)
            flag_error($sformatf("%0d line samples never arrived", line_expect_q.size()));
        if (error_count == 0)
            $display("tb_dmx512_frame_transmitter_core passed");
        else
            $display("tb_dmx512_frame_transmitter_core failed");
        $finish;
    end

endmodule
